/* hdl/accumulator_cpu_step_macros.svh */
// Assertion macros used by the RTL.
`ifndef ACCUMULATOR_CPU_STEP_MACROS_SVH
`define ACCUMULATOR_CPU_STEP_MACROS_SVH

// Asserts that a property holds at every rising clock edge outside reset.
`define ACS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Asserts that a cause is always followed by an effect in the next cycle.
`define ACS_ASSERT_NEXT(label, clk, rst_n, cause, effect, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
        else $error(msg);

`endif

/* hdl/acs_pkg.sv */
`default_nettype none
package acs_pkg;
    localparam int unsigned OPC_W = 4;
    typedef logic [OPC_W-1:0] opcode_t;
    localparam opcode_t OPC_OUT   = 4'd0;
    localparam opcode_t OPC_ADD   = 4'd1;
    localparam opcode_t OPC_LOAD  = 4'd2;
    localparam opcode_t OPC_NOP   = 4'd3;
    localparam opcode_t OPC_SUB   = 4'd4;
    localparam opcode_t OPC_MUL   = 4'd5;
    localparam opcode_t OPC_DIV   = 4'd6;
    localparam opcode_t OPC_BRA   = 4'd7;
    localparam opcode_t OPC_BRZ   = 4'd8;
    localparam opcode_t OPC_BRP   = 4'd9;
    localparam opcode_t OPC_STORE = 4'd10;
    localparam opcode_t OPC_INPUT = 4'd11;
    localparam opcode_t OPC_HALT  = 4'd12;

    localparam int unsigned ADDR_W = 5;
    localparam int unsigned FIELD_W = 32;
    localparam int unsigned PC_W = 6;

    typedef enum logic [1:0] {
        AOP_ADD,
        AOP_SUB,
        AOP_MUL,
        AOP_DIV
    } alu_op_t;
endpackage
`default_nettype wire

/* hdl/accumulator_cpu_step.sv */
`default_nettype none
// Accumulator machine with a shared program and data memory.
// Drive op, addr, write_data and input_value and pulse start while busy is
// low; the item is transferred at that edge and busy rises. op 0 writes one
// memory word, op 1 executes one instruction at the program counter.
// Exactly one result follows per item: done is high for one cycle with
// out_valid, out_value, halted, error, prog_counter and accumulator.
// A write item passes the write and finish states and an instruction the
// states fetch, opcode, operand, execute and finish, plus a wait on the
// bit-serial arithmetic unit when it uses it (ADD, SUB, MUL, DIV by a
// nonzero value). done rises as busy falls, and the next item can be
// transferred in that same cycle. A step while halted goes straight to finish.
// The memory read port is registered, one word per cycle.
// Reset clears the counter, accumulator and halt flag at once; then a
// clearing pass writes the no-op code into every word, during which busy
// stays high.
// The receiver cannot stall: done marks each result for one cycle, and the result ports hold it until the next item.
module accumulator_cpu_step #(
    parameter int unsigned MEM_DEPTH  = 32,
    parameter int unsigned WORD_WIDTH = 32
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            start,
    output logic                           busy,
    output logic                           done,
    input  wire                            op,
    input  wire  [acs_pkg::ADDR_W-1:0]     addr,
    input  wire  signed [acs_pkg::FIELD_W-1:0] write_data,
    input  wire  signed [acs_pkg::FIELD_W-1:0] input_value,
    output logic                           out_valid,
    output logic signed [acs_pkg::FIELD_W-1:0] out_value,
    output logic                           halted,
    output logic                           error,
    output logic [acs_pkg::PC_W-1:0]       prog_counter,
    output logic signed [acs_pkg::FIELD_W-1:0] accumulator
);
    import acs_pkg::*;

    `include "accumulator_cpu_step_macros.svh"

    localparam int unsigned MA_W = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int unsigned PCI_W = $clog2(MEM_DEPTH + 1);
    localparam logic [PCI_W-1:0] PC_END = PCI_W'(MEM_DEPTH);
    localparam logic [WORD_WIDTH-1:0] NOP_WORD = WORD_WIDTH'(OPC_NOP);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WRITE,
        S_FETCH,
        S_OPC,
        S_ARG,
        S_EXEC,
        S_ALU,
        S_DONE
    } state_t;

    logic [WORD_WIDTH-1:0] mem [MEM_DEPTH];
    logic [WORD_WIDTH-1:0] rd_reg;

    state_t                state_reg;
    logic [PCI_W-1:0]      pc_reg;
    logic [WORD_WIDTH-1:0] acc_reg;
    logic                  stopped_reg;
    logic [MA_W-1:0]       clr_reg;
    logic [WORD_WIDTH-1:0] opw_reg;
    logic                  out_valid_reg;
    logic [WORD_WIDTH-1:0] out_value_reg;
    logic                  error_reg;
    logic                  done_reg;
    logic [ADDR_W-1:0]     addr_reg;
    logic [FIELD_W-1:0]    wdata_reg;
    logic [FIELD_W-1:0]    in_reg;

    logic                  mem_we;
    logic [MA_W-1:0]       mem_wa;
    logic [WORD_WIDTH-1:0] mem_wd;
    logic [MA_W-1:0]       mem_ra;

    logic                  alu_start;
    alu_op_t               alu_op;
    logic                  alu_done;
    logic [WORD_WIDTH-1:0] alu_result;

    logic                  pc_in;
    logic [WORD_WIDTH-1:0] arg;
    logic                  op_known;
    opcode_t               opc;
    logic                  take_branch;
    logic [PCI_W-1:0]      jump_pc;
    logic [PCI_W-1:0]      pc_next;
    logic [PCI_W-1:0]      pc_plus;

    acs_alu #(
        .WORD_WIDTH(WORD_WIDTH)
    ) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (alu_start),
        .alu_op (alu_op),
        .a      (acc_reg),
        .b      (arg),
        .done   (alu_done),
        .result (alu_result)
    );

    always_comb
    begin
        pc_in    = (pc_reg < PC_END);
        arg      = pc_in ? rd_reg : '0;
        op_known = (opw_reg <= WORD_WIDTH'(OPC_HALT));
        opc      = op_known ? opcode_t'(opw_reg) : OPC_NOP;
        pc_plus  = pc_in ? pc_reg + 1'b1 : pc_reg;
        if (arg[WORD_WIDTH-1] || (arg >= WORD_WIDTH'(MEM_DEPTH)))
            jump_pc = PC_END;
        else
            jump_pc = PCI_W'(arg);
        unique case (opc)
            OPC_BRA: take_branch = 1'b1;
            OPC_BRZ: take_branch = (acc_reg == '0);
            OPC_BRP: take_branch = !acc_reg[WORD_WIDTH-1];
            default: take_branch = 1'b0;
        endcase
        unique case (opc)
            OPC_ADD:  alu_op = AOP_ADD;
            OPC_SUB:  alu_op = AOP_SUB;
            OPC_MUL:  alu_op = AOP_MUL;
            default:  alu_op = AOP_DIV;
        endcase
        alu_start = (state_reg == S_EXEC) &&
                    (opc == OPC_ADD || opc == OPC_SUB || opc == OPC_MUL ||
                     (opc == OPC_DIV && arg != '0));
        if (take_branch)
            pc_next = jump_pc;
        else if (opc == OPC_OUT || opc == OPC_INPUT || opc == OPC_NOP ||
                 opc == OPC_BRA)
            pc_next = pc_reg;
        else if (opc == OPC_HALT)
            pc_next = PC_END;
        else
            pc_next = pc_plus;

        mem_we = 1'b0;
        mem_wa = clr_reg;
        mem_wd = NOP_WORD;
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
            end
            S_WRITE:
            begin
                mem_we = (32'(addr_reg) < MEM_DEPTH);
                mem_wa = MA_W'(addr_reg);
                mem_wd = WORD_WIDTH'(signed'(wdata_reg));
            end
            S_EXEC:
            begin
                mem_we = (opc == OPC_STORE) && pc_in;
                mem_wa = MA_W'(pc_reg);
                mem_wd = acc_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
        mem_ra = MA_W'(pc_reg);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rd_reg <= mem[mem_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            pc_reg        <= '0;
            acc_reg       <= '0;
            stopped_reg   <= 1'b0;
            clr_reg       <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_value_reg <= '0;
            error_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (32'(clr_reg) == MEM_DEPTH - 1)
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        addr_reg      <= addr;
                        wdata_reg     <= write_data;
                        in_reg        <= input_value;
                        out_valid_reg <= 1'b0;
                        out_value_reg <= '0;
                        error_reg     <= 1'b0;
                        if (!op)
                            state_reg <= S_WRITE;
                        else if (stopped_reg)
                            state_reg <= S_DONE;
                        else if (!pc_in)
                        begin
                            stopped_reg <= 1'b1;
                            state_reg   <= S_DONE;
                        end
                        else
                            state_reg <= S_FETCH;
                    end
                end
                S_WRITE:
                begin
                    state_reg <= S_DONE;
                end
                S_FETCH:
                begin
                    pc_reg    <= pc_reg + 1'b1;
                    state_reg <= S_OPC;
                end
                S_OPC:
                begin
                    opw_reg   <= rd_reg;
                    state_reg <= S_ARG;
                end
                S_ARG:
                begin
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    pc_reg <= pc_next;
                    if (pc_next >= PC_END)
                        stopped_reg <= 1'b1;
                    unique case (opc)
                        OPC_OUT:
                        begin
                            out_valid_reg <= 1'b1;
                            out_value_reg <= acc_reg;
                        end
                        OPC_LOAD:  acc_reg <= arg;
                        OPC_INPUT: acc_reg <= WORD_WIDTH'(signed'(in_reg));
                        OPC_DIV:   error_reg <= (arg == '0);
                        default:   acc_reg <= acc_reg;
                    endcase
                    state_reg <= alu_start ? S_ALU : S_DONE;
                end
                S_ALU:
                begin
                    if (alu_done)
                    begin
                        acc_reg   <= alu_result;
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign out_valid    = out_valid_reg;
    assign out_value    = FIELD_W'(signed'(out_value_reg));
    assign halted       = stopped_reg;
    assign error        = error_reg;
    assign prog_counter = PC_W'(pc_reg);
    assign accumulator  = FIELD_W'(signed'(acc_reg));

    `ACS_ASSERT(a_pc_range, clk, rst_n, pc_reg <= PC_END, "program counter beyond end")
    `ACS_ASSERT(a_halt_pc, clk, rst_n, !done_reg || !stopped_reg || pc_reg == PC_END,
                "halted with counter inside memory")
    `ACS_ASSERT(a_done_idle, clk, rst_n, !done_reg || !busy, "result outside idle")
    `ACS_ASSERT_NEXT(a_one_done, clk, rst_n, done_reg, !done_reg,
                     "result strobe longer than one cycle")
endmodule
`default_nettype wire

/* hdl/acs_alu.sv */
`default_nettype none
// Bit-serial arithmetic unit: add and subtract ripple one bit per cycle,
// multiply is shift-and-add over the operand bits, divide is restoring
// division on magnitudes, one quotient bit per cycle.
module acs_alu #(
    parameter int unsigned WORD_WIDTH = 32
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      start,
    input  acs_pkg::alu_op_t         alu_op,
    input  wire  [WORD_WIDTH-1:0]    a,
    input  wire  [WORD_WIDTH-1:0]    b,
    output logic                     done,
    output logic [WORD_WIDTH-1:0]    result
);
    import acs_pkg::*;

    localparam int unsigned CNT_W = $clog2(WORD_WIDTH + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_WIDTH - 1);

    logic                  busy_reg;
    logic [CNT_W-1:0]      cnt_reg;
    alu_op_t               op_reg;
    logic [WORD_WIDTH-1:0] x_reg;
    logic [WORD_WIDTH-1:0] y_reg;
    logic [WORD_WIDTH-1:0] r_reg;
    logic [WORD_WIDTH:0]   rem_reg;
    logic                  carry_reg;
    logic                  neg_reg;
    logic                  done_reg;

    logic                  sum_bit;
    logic                  carry_next;
    logic                  y_bit;
    logic [WORD_WIDTH:0]   rem_shift;
    logic [WORD_WIDTH:0]   rem_diff;
    logic [WORD_WIDTH-1:0] a_mag;
    logic [WORD_WIDTH-1:0] b_mag;
    logic [WORD_WIDTH-1:0] mul_sum;

    always_comb
    begin
        y_bit      = (op_reg == AOP_SUB) ? ~y_reg[0] : y_reg[0];
        sum_bit    = x_reg[0] ^ y_bit ^ carry_reg;
        carry_next = (x_reg[0] & y_bit) | (carry_reg & (x_reg[0] ^ y_bit));
        rem_shift  = {rem_reg[WORD_WIDTH-1:0], x_reg[WORD_WIDTH-1]};
        rem_diff   = rem_shift - {1'b0, y_reg};
        mul_sum    = r_reg + (y_reg[0] ? x_reg : '0);
        a_mag      = a[WORD_WIDTH-1] ? (~a + 1'b1) : a;
        b_mag      = b[WORD_WIDTH-1] ? (~b + 1'b1) : b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                cnt_reg   <= '0;
                op_reg    <= alu_op;
                carry_reg <= (alu_op == AOP_SUB);
                r_reg     <= '0;
                rem_reg   <= '0;
                neg_reg   <= a[WORD_WIDTH-1] ^ b[WORD_WIDTH-1];
                if (alu_op == AOP_DIV)
                begin
                    x_reg <= a_mag;
                    y_reg <= b_mag;
                end
                else
                begin
                    x_reg <= a;
                    y_reg <= b;
                end
            end
            else if (busy_reg)
            begin
                unique case (op_reg)
                    AOP_ADD, AOP_SUB:
                    begin
                        r_reg     <= {sum_bit, r_reg[WORD_WIDTH-1:1]};
                        carry_reg <= carry_next;
                        x_reg     <= x_reg >> 1;
                        y_reg     <= y_reg >> 1;
                    end
                    AOP_MUL:
                    begin
                        r_reg <= mul_sum;
                        x_reg <= x_reg << 1;
                        y_reg <= y_reg >> 1;
                    end
                    AOP_DIV:
                    begin
                        x_reg <= x_reg << 1;
                        if (!rem_diff[WORD_WIDTH])
                        begin
                            rem_reg <= rem_diff;
                            r_reg   <= {r_reg[WORD_WIDTH-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= rem_shift;
                            r_reg   <= {r_reg[WORD_WIDTH-2:0], 1'b0};
                        end
                    end
                    default:
                    begin
                        r_reg <= r_reg;
                    end
                endcase
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    assign done   = done_reg;
    assign result = (op_reg == AOP_DIV && neg_reg) ? (~r_reg + 1'b1) : r_reg;
endmodule
`default_nettype wire

/* bench/tb_accumulator_cpu_step.sv */
`default_nettype none
module tb_accumulator_cpu_step;
    timeunit 1ns;
    timeprecision 1ps;
    import acs_pkg::*;

    localparam int DEPTH = 32;
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_STEP = 1'b1;

    typedef struct packed {
        logic out_valid;
        logic [31:0] out_value;
        logic halted;
        logic error;
        logic [5:0] prog_counter;
        logic [31:0] accumulator;
    } cpu_state_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic done;
    logic op;
    logic [ADDR_W-1:0] addr;
    logic signed [FIELD_W-1:0] write_data;
    logic signed [FIELD_W-1:0] input_value;
    logic out_valid;
    logic signed [FIELD_W-1:0] out_value;
    logic halted;
    logic error;
    logic [PC_W-1:0] prog_counter;
    logic signed [FIELD_W-1:0] accumulator;

    logic [31:0] shadow_mem [DEPTH];
    int shadow_pc;
    logic [31:0] shadow_acc;
    logic shadow_stopped;
    cpu_state_t pending_states[$];
    int fail_count;
    int idle_pct;

    accumulator_cpu_step uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .done(done),
        .op(op),
        .addr(addr),
        .write_data(write_data),
        .input_value(input_value),
        .out_valid(out_valid),
        .out_value(out_value),
        .halted(halted),
        .error(error),
        .prog_counter(prog_counter),
        .accumulator(accumulator)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #8ms;
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [31:0] fetch_operand();
        return (shadow_pc < DEPTH) ? shadow_mem[shadow_pc] : 32'd0;
    endfunction

    function automatic void branch_to(logic [31:0] target);
        if ($signed(target) < 0 || $signed(target) >= DEPTH)
            shadow_pc = DEPTH;
        else
            shadow_pc = int'(target);
    endfunction

    function automatic cpu_state_t execute_item(logic is_step, logic [4:0] a,
                                                logic [31:0] wd, logic [31:0] iv);
        cpu_state_t r;
        logic [31:0] opw;
        logic [31:0] arg;
        longint q;
        r = '0;
        if (!is_step)
        begin
            shadow_mem[a] = wd;
        end
        else if (!shadow_stopped)
        begin
            if (shadow_pc < DEPTH)
            begin
                opw = shadow_mem[shadow_pc];
                shadow_pc++;
                arg = fetch_operand();
                if (opw == 32'(OPC_OUT))
                begin
                    r.out_valid = 1'b1;
                    r.out_value = shadow_acc;
                end
                else if (opw == 32'(OPC_ADD))
                begin
                    shadow_acc = shadow_acc + arg;
                    shadow_pc++;
                end
                else if (opw == 32'(OPC_LOAD))
                begin
                    shadow_acc = arg;
                    shadow_pc++;
                end
                else if (opw == 32'(OPC_SUB))
                begin
                    shadow_acc = shadow_acc - arg;
                    shadow_pc++;
                end
                else if (opw == 32'(OPC_MUL))
                begin
                    shadow_acc = shadow_acc * arg;
                    shadow_pc++;
                end
                else if (opw == 32'(OPC_DIV))
                begin
                    if (arg == 32'd0)
                        r.error = 1'b1;
                    else
                    begin
                        q = longint'($signed(shadow_acc)) / longint'($signed(arg));
                        shadow_acc = q[31:0];
                    end
                    shadow_pc++;
                end
                else if (opw == 32'(OPC_BRA))
                    branch_to(arg);
                else if (opw == 32'(OPC_BRZ))
                begin
                    if (shadow_acc == 32'd0) branch_to(arg);
                    else shadow_pc++;
                end
                else if (opw == 32'(OPC_BRP))
                begin
                    if (!shadow_acc[31]) branch_to(arg);
                    else shadow_pc++;
                end
                else if (opw == 32'(OPC_STORE))
                begin
                    if (shadow_pc < DEPTH) shadow_mem[shadow_pc] = shadow_acc;
                    shadow_pc++;
                end
                else if (opw == 32'(OPC_INPUT))
                    shadow_acc = iv;
                else if (opw == 32'(OPC_HALT))
                    shadow_pc = DEPTH;
            end
            if (shadow_pc >= DEPTH)
            begin
                shadow_pc = DEPTH;
                shadow_stopped = 1'b1;
            end
        end
        r.halted = shadow_stopped;
        r.prog_counter = 6'(shadow_pc);
        r.accumulator = shadow_acc;
        return r;
    endfunction

    task automatic send_item(logic is_step, logic [4:0] a, logic [31:0] wd,
                             logic [31:0] iv);
        op <= is_step;
        addr <= a;
        write_data <= wd;
        input_value <= iv;
        start <= 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        pending_states.push_back(execute_item(is_step, a, wd, iv));
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct) @(posedge clk);
        end
    endtask

    task automatic write_word(int a, logic [31:0] w);
        send_item(OP_WRITE, 5'(a), w, $urandom());
    endtask

    task automatic step_cpu(logic [31:0] iv);
        send_item(OP_STEP, 5'($urandom()), $urandom(), iv);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_states.size() != 0) @(posedge clk);
        repeat (45) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        cpu_state_t e;
        if (rst_n && done)
        begin
            if (pending_states.size() == 0)
            begin
                $error("result transfer with nothing expected");
                fail_count++;
            end
            else
            begin
                e = pending_states.pop_front();
                if (out_valid !== e.out_valid)
                begin
                    $error("out_valid: expected %0d, got %0d", e.out_valid, out_valid);
                    fail_count++;
                end
                if (out_value !== e.out_value)
                begin
                    $error("out_value: expected %0d, got %0d", $signed(e.out_value),
                           out_value);
                    fail_count++;
                end
                if (halted !== e.halted)
                begin
                    $error("halted: expected %0d, got %0d", e.halted, halted);
                    fail_count++;
                end
                if (error !== e.error)
                begin
                    $error("error: expected %0d, got %0d", e.error, error);
                    fail_count++;
                end
                if (prog_counter !== e.prog_counter)
                begin
                    $error("prog_counter: expected %0d, got %0d", e.prog_counter,
                           prog_counter);
                    fail_count++;
                end
                if (accumulator !== e.accumulator)
                begin
                    $error("accumulator: expected %0d, got %0d", $signed(e.accumulator),
                           accumulator);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_directed_ops();
        logic [31:0] prog [25];
        prog = '{32'(OPC_INPUT), 32'(OPC_ADD), 32'd1, 32'(OPC_OUT), 32'(OPC_DIV), 32'd0,
                 32'(OPC_DIV), 32'hFFFF_FFFF, 32'(OPC_BRZ), 32'd0, 32'(OPC_LOAD), 32'd0,
                 32'(OPC_BRZ), 32'd14, 32'(OPC_BRP), 32'd16, 32'(OPC_STORE), 32'd77,
                 32'd99, 32'(OPC_SUB), 32'd1, 32'(OPC_MUL), 32'hFFFF_FFFB,
                 32'(OPC_BRA), 32'd0};
        idle_pct = 0;
        for (int i = 0; i < 25; i++)
            write_word(i, prog[i]);
        write_word(31, 32'h8000_0000);
        step_cpu(32'h7FFF_FFFF);
        repeat (13) step_cpu(32'h8000_0000);
        step_cpu(32'h8000_0000);
    endtask

    task automatic load_random_program();
        int a;
        int pick;
        logic [31:0] opc;
        logic [31:0] arg;
        a = 0;
        while (a < 29)
        begin
            pick = $urandom_range(11);
            opc = (pick == 11) ? 32'(OPC_INPUT) : 32'(pick);
            write_word(a, opc);
            a++;
            if (opc inside {32'(OPC_ADD), 32'(OPC_LOAD), 32'(OPC_SUB), 32'(OPC_MUL),
                            32'(OPC_DIV), 32'(OPC_BRA), 32'(OPC_BRZ), 32'(OPC_BRP),
                            32'(OPC_STORE)})
            begin
                if (opc inside {32'(OPC_BRA), 32'(OPC_BRZ), 32'(OPC_BRP)})
                    arg = $urandom_range(29);
                else if ($urandom_range(4) == 0)
                    arg = 32'($urandom_range(2)) - 32'd1;
                else if ($urandom_range(1) == 0)
                    arg = $urandom_range(100);
                else
                    arg = $urandom();
                write_word(a, arg);
                a++;
            end
        end
        while (a < 30)
        begin
            write_word(a, 32'(OPC_NOP));
            a++;
        end
        write_word(30, 32'(OPC_BRA));
        write_word(31, 32'd0);
    endtask

    task automatic test_random_programs(int pct, int bursts);
        idle_pct = pct;
        repeat (bursts)
        begin
            load_random_program();
            repeat ($urandom_range(8, 24))
            begin
                if ($urandom_range(9) == 0)
                    write_word($urandom_range(31), $urandom());
                else
                    step_cpu($urandom());
            end
        end
    endtask

    task automatic test_stop_conditions();
        int mode;
        idle_pct = 6;
        mode = $urandom_range(2);
        for (int i = 0; i < DEPTH; i++)
            write_word(i, 32'(OPC_NOP));
        if (mode == 0)
            write_word(28, 32'(OPC_HALT));
        else if (mode == 1)
        begin
            write_word(28, 32'(OPC_BRA));
            write_word(29, ($urandom_range(1) == 0) ? 32'hFFFF_FFF0 : 32'd40);
        end
        while (!shadow_stopped) step_cpu($urandom());
        step_cpu($urandom());
        write_word(0, 32'(OPC_OUT));
        step_cpu($urandom());
    endtask

    initial
    begin
        fail_count = 0;
        idle_pct = 0;
        for (int i = 0; i < DEPTH; i++) shadow_mem[i] = 32'(OPC_NOP);
        shadow_pc = 0;
        shadow_acc = '0;
        shadow_stopped = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        op = OP_WRITE;
        addr = '0;
        write_data = '0;
        input_value = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_ops();
        drain_results();
        test_random_programs(0, 4);
        test_random_programs(80, 4);
        drain_results();
        test_random_programs(0, 4);
        test_random_programs(6, 5);
        test_stop_conditions();
        drain_results();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire

/* filelist.f */
+incdir+hdl
hdl/acs_pkg.sv
hdl/acs_alu.sv
hdl/accumulator_cpu_step.sv
bench/tb_accumulator_cpu_step.sv
